[sv/nbhm_pkg.sv]
package nbhm_pkg;

  // Table geometry
  localparam int MAX_ENTRIES   = 4096;
  localparam int BARCODE_CHARS = 32;
  localparam int CHAR_W        = 3;
  localparam int BASES_W       = 48;
  localparam int IDX_W         = $clog2(MAX_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int LEN_W         = 6;
  localparam int ENTRY_W       = 2 * BASES_W + LEN_W;

  // Distance reported when no entry was scanned
  localparam int DIST_NONE     = BARCODE_CHARS + 1;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIQUE_ONLY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT     = 2'd2;

  typedef logic [BARCODE_CHARS-1:0] mismatch_t;

endpackage

[sv/nbhm_ram.sv]
module nbhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/nearest_barcode_hamming_match.sv]
// Whitelist barcode matcher. A load item (operation 0) writes one barcode and
// its length into the entry table and produces no result. A query item
// (operation 1) scans entries 0 to entry_count-1, with entry_count clamped
// to 4096, through the table's single read port, one entry per cycle, in a
// four-stage pipe (read, compare characters, count mismatches, update best).
// A query holds the input until its result is handed to the output register,
// which happens once that register is free; an exact match ends
// the scan once that entry's distance reaches the update stage. The result is
// the first entry at the smallest Hamming distance (counted over the shorter
// of the two lengths) and the number of scanned entries at that distance. The
// next item is taken while a result waits on the output. Configuration writes
// are taken at any time but must only be issued while the block is idle.
module nearest_barcode_hamming_match (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [nbhm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [nbhm_pkg::CFG_DATA_W-1:0]        cfg_data,
  // Input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_operation,
  input  logic [nbhm_pkg::IDX_W-1:0]             in_entry_index,
  input  logic [nbhm_pkg::BASES_W-1:0]           in_bases_low,
  input  logic [nbhm_pkg::BASES_W-1:0]           in_bases_high,
  input  logic [nbhm_pkg::LEN_W-1:0]             in_char_count,
  // Result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_accepted,
  output logic [nbhm_pkg::IDX_W-1:0]             out_match_index,
  output logic [nbhm_pkg::LEN_W-1:0]             out_min_distance,
  output logic [nbhm_pkg::CNT_W-1:0]             out_tie_count,
  output logic                                   out_multiple_match
);

  import nbhm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Count set bits of the mismatch vector as an adder tree
  function automatic logic [LEN_W-1:0] popcount(input mismatch_t v);
    logic [2:0] quad [8];
    logic [3:0] pair [4];
    logic [4:0] half [2];
    for (int g = 0; g < 8; g++) begin
      quad[g] = (3'(v[4*g]) + 3'(v[4*g+1])) + (3'(v[4*g+2]) + 3'(v[4*g+3]));
    end
    for (int g = 0; g < 4; g++) begin
      pair[g] = 4'(quad[2*g]) + 4'(quad[2*g+1]);
    end
    for (int g = 0; g < 2; g++) begin
      half[g] = 5'(pair[2*g]) + 5'(pair[2*g+1]);
    end
    return LEN_W'(half[0]) + LEN_W'(half[1]);
  endfunction

  // Control state
  logic [1:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             s1_v_r, s1_v_nxt;
  logic             s2_v_r, s2_v_nxt;
  logic             s3_v_r, s3_v_nxt;
  logic [LEN_W-1:0] thr_r;
  logic             uniq_r;
  logic [CNT_W-1:0] entry_count_r;

  // Query and scan payload
  logic [BASES_W-1:0] q_lo_r, q_lo_nxt;
  logic [BASES_W-1:0] q_hi_r, q_hi_nxt;
  logic [LEN_W-1:0]   q_len_r, q_len_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic [IDX_W-1:0]   s1_idx_r, s1_idx_nxt;
  logic [IDX_W-1:0]   s2_idx_r, s2_idx_nxt;
  logic [IDX_W-1:0]   s3_idx_r, s3_idx_nxt;
  mismatch_t          mm_r, mm_nxt;
  logic [LEN_W-1:0]   dist_r, dist_nxt;
  logic [LEN_W-1:0]   best_r, best_nxt;
  logic [CNT_W-1:0]   ties_r, ties_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;

  // Output payload
  logic             o_acc_r, o_acc_nxt;
  logic [IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic [LEN_W-1:0] o_dist_r, o_dist_nxt;
  logic [CNT_W-1:0] o_ties_r, o_ties_nxt;
  logic             o_multi_r, o_multi_nxt;

  // Table port signals
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [LEN_W-1:0]   in_len;
  logic [BASES_W*2-1:0] q_bases;
  logic [BASES_W*2-1:0] e_bases;
  logic [LEN_W-1:0]   e_len;
  logic [LEN_W-1:0]   cmp_len;
  logic               issue;
  logic               hit;
  logic               acc;
  logic               in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Clamp the character count of loads and queries
  assign in_len = (in_char_count > LEN_W'(BARCODE_CHARS)) ? LEN_W'(BARCODE_CHARS)
                                                          : in_char_count;

  assign ram_we    = in_fire && (in_operation == OP_LOAD);
  assign ram_wdata = {in_len, in_bases_high, in_bases_low};

  nbhm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_entry_index),
    .wdata (ram_wdata),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Split the entry read back from the table
  assign q_bases = {q_hi_r, q_lo_r};
  assign e_bases = ram_rdata[BASES_W*2-1:0];
  assign e_len   = ram_rdata[ENTRY_W-1:BASES_W*2];
  assign cmp_len = (q_len_r < e_len) ? q_len_r : e_len;

  assign issue = (state_r == ST_SCAN) && (issue_r < count_r) && !hit;
  assign hit   = (state_r == ST_SCAN) && s3_v_r && (dist_r == '0);

  // Acceptance of the finished scan
  assign acc = (best_r != LEN_W'(DIST_NONE)) && (best_r <= thr_r) &&
               (!uniq_r || (ties_r == CNT_W'(1)));

  always_comb begin
    state_nxt    = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_lo_nxt     = q_lo_r;
    q_hi_nxt     = q_hi_r;
    q_len_nxt    = q_len_r;
    count_nxt    = count_r;
    issue_nxt    = issue_r;
    best_nxt     = best_r;
    ties_nxt     = ties_r;
    best_idx_nxt = best_idx_r;
    o_acc_nxt    = o_acc_r;
    o_idx_nxt    = o_idx_r;
    o_dist_nxt   = o_dist_r;
    o_ties_nxt   = o_ties_r;
    o_multi_nxt  = o_multi_r;

    // Advance the scan pipe
    s1_v_nxt   = issue;
    s1_idx_nxt = issue_r[IDX_W-1:0];
    s2_v_nxt   = s1_v_r;
    s2_idx_nxt = s1_idx_r;
    s3_v_nxt   = s2_v_r;
    s3_idx_nxt = s2_idx_r;
    dist_nxt   = popcount(mm_r);
    for (int i = 0; i < BARCODE_CHARS; i++) begin
      mm_nxt[i] = (q_bases[i*CHAR_W +: CHAR_W] != e_bases[i*CHAR_W +: CHAR_W]) &&
                  (LEN_W'(i) < cmp_len);
    end

    unique case (state_r)
      ST_IDLE: begin
        // Start a query; loads finish in the table write
        if (in_fire && (in_operation == OP_QUERY)) begin
          q_lo_nxt     = in_bases_low;
          q_hi_nxt     = in_bases_high;
          q_len_nxt    = in_len;
          count_nxt    = (entry_count_r > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                               : entry_count_r;
          issue_nxt    = '0;
          best_nxt     = LEN_W'(DIST_NONE);
          ties_nxt     = '0;
          best_idx_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        // Fold one distance into the running minimum
        if (s3_v_r) begin
          if (dist_r == best_r) begin
            ties_nxt = ties_r + CNT_W'(1);
          end
          if (dist_r < best_r) begin
            best_nxt     = dist_r;
            ties_nxt     = CNT_W'(1);
            best_idx_nxt = s3_idx_r;
          end
        end
        // Stop on an exact match or once the pipe has drained
        if (hit || (!issue && !s1_v_r && !s2_v_r && !s3_v_r)) begin
          s1_v_nxt  = 1'b0;
          s2_v_nxt  = 1'b0;
          s3_v_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          o_acc_nxt     = acc;
          o_idx_nxt     = acc ? best_idx_r : '0;
          o_dist_nxt    = best_r;
          o_ties_nxt    = ties_r;
          o_multi_nxt   = acc && (ties_r > CNT_W'(1));
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
      thr_r         <= LEN_W'(1);
      uniq_r        <= 1'b1;
      entry_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      s3_v_r      <= s3_v_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MATCH_THRESHOLD: thr_r         <= cfg_data[LEN_W-1:0];
          REG_UNIQUE_ONLY:     uniq_r        <= cfg_data[0];
          REG_ENTRY_COUNT:     entry_count_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q_lo_r     <= q_lo_nxt;
    q_hi_r     <= q_hi_nxt;
    q_len_r    <= q_len_nxt;
    count_r    <= count_nxt;
    issue_r    <= issue_nxt;
    s1_idx_r   <= s1_idx_nxt;
    s2_idx_r   <= s2_idx_nxt;
    s3_idx_r   <= s3_idx_nxt;
    mm_r       <= mm_nxt;
    dist_r     <= dist_nxt;
    best_r     <= best_nxt;
    ties_r     <= ties_nxt;
    best_idx_r <= best_idx_nxt;
    o_acc_r    <= o_acc_nxt;
    o_idx_r    <= o_idx_nxt;
    o_dist_r   <= o_dist_nxt;
    o_ties_r   <= o_ties_nxt;
    o_multi_r  <= o_multi_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = o_acc_r;
  assign out_match_index    = o_idx_r;
  assign out_min_distance   = o_dist_r;
  assign out_tie_count      = o_ties_r;
  assign out_multiple_match = o_multi_r;

  // A counted distance never exceeds the barcode length
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && s3_v_r) |-> (dist_r <= LEN_W'(BARCODE_CHARS)))
    else $error("distance out of range");

  // An empty scan reports no ties, a nonempty one at least one
  a_empty_ties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((o_dist_r == LEN_W'(DIST_NONE)) == (o_ties_r == '0)))
    else $error("tie count disagrees with empty table");

  // A multiple match is an accepted query with several ties
  a_multi: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_multi_r) |-> (o_acc_r && (o_ties_r > CNT_W'(1))))
    else $error("multiple match without accepted ties");

  // No entry read is issued outside a scan or past the entry count
  a_issue: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> ($past(state_r) == ST_SCAN && $past(issue_r) < $past(count_r)))
    else $error("entry read outside scan");

endmodule
